>>> rtl/fvnh_pkg.sv
package fvnh_pkg;

    // Field and datapath widths.
    localparam int POS_W    = 24;
    localparam int HEIGHT_W = 18;
    localparam int FRAC_W   = 16;
    // The octave sum stays below 2^25 for any number of octaves.
    localparam int ACC_W    = 25;

    // Pipeline depth of one octave cell.
    localparam int CELL_STAGES = 5;

    // Corner hash constants.
    localparam logic [31:0] HASH_KX   = 32'd374761393;
    localparam logic [31:0] HASH_KZ   = 32'd668265263;
    localparam logic [31:0] HASH_KM   = 32'd1274126177;
    localparam int          SEED_STEP = 7919;

    // Q0.16 one, and three in the smoothstep polynomial.
    localparam logic [16:0] ONE_Q16      = 17'h10000;
    localparam logic [17:0] SMOOTH_THREE = 18'd196608;

    // Output scale and saturation limit.
    localparam logic [4:0]          HEIGHT_SCALE = 5'd18;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 18'd143359;

    // Configuration register index.
    localparam logic REG_NOISE_SEED = 1'b0;

    // Data handed from one octave cell to the next.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] pz;
        logic [ACC_W-1:0] acc;
    } link_t;

    // Linear blend of two Q0.16 values with a Q0.16 weight on b.
    function automatic logic [15:0] lerp_q16(input logic [15:0] a,
                                             input logic [15:0] b,
                                             input logic [15:0] u);
        logic [16:0] inv;
        logic [32:0] sum;
        inv = ONE_Q16 - {1'b0, u};
        sum = 33'(a) * 33'(inv) + 33'(b) * 33'(u);
        return sum[31:16];
    endfunction

endpackage

>>> rtl/fvnh_cell.sv
module fvnh_cell #(
    parameter int OCT_IDX    = 0,
    parameter int FRAC_SHIFT = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic [31:0]     seed_i,
    input  fvnh_pkg::link_t link_i,
    output fvnh_pkg::link_t link_o
);
    import fvnh_pkg::*;

    localparam logic [31:0] SeedOfs = 32'(OCT_IDX * SEED_STEP);

    // Position and running sum travel alongside the octave math.
    link_t lk_reg [1:CELL_STAGES];

    // Stage 1: lattice split, hash products, fraction squares.
    logic [31:0]             xi, zi;
    logic [FRAC_SHIFT+15:0]  wide_x, wide_z;
    logic [FRAC_W-1:0]       fx, fz;
    logic [31:0]             xk_reg, zk_reg, seed1_reg;
    logic [FRAC_W-1:0]       fx_reg, fz_reg;
    logic [31:0]             fxsq_reg, fzsq_reg;

    assign xi     = 32'(link_i.px >> FRAC_SHIFT);
    assign zi     = 32'(link_i.pz >> FRAC_SHIFT);
    // Places the fraction bits at Q0.16, truncating when there are more than 16.
    assign wide_x = {link_i.px[FRAC_SHIFT-1:0], 16'b0};
    assign wide_z = {link_i.pz[FRAC_SHIFT-1:0], 16'b0};
    assign fx     = FRAC_W'(wide_x >> FRAC_SHIFT);
    assign fz     = FRAC_W'(wide_z >> FRAC_SHIFT);

    // Stage 2: corner sums with the first xorshift; smoothstep product.
    logic [31:0] g_next [4];
    logic [31:0] g_reg  [4];
    logic [33:0] tx_reg, tz_reg;
    logic [17:0] tx_poly, tz_poly;

    always_comb begin
        logic [31:0] h;
        for (int c = 0; c < 4; c++) begin
            // Corner c has x + 1 in bit 0 and z + 1 in bit 1.
            h = xk_reg + zk_reg + seed1_reg
              + (c[0] ? HASH_KX : 32'd0) + (c[1] ? HASH_KZ : 32'd0);
            g_next[c] = h ^ (h >> 13);
        end
    end

    assign tx_poly = SMOOTH_THREE - 18'({fx_reg, 1'b0});
    assign tz_poly = SMOOTH_THREE - 18'({fz_reg, 1'b0});

    // Stage 3: final hash multiply; smoothstep weights.
    logic [31:0]       m_reg [4];
    logic [FRAC_W-1:0] ux_reg, uz_reg;

    // Stage 4: corner values and the two row blends. The last xorshift by 16
    // leaves the top half untouched, so the corner value is the top half.
    logic [15:0]       top_reg, bot_reg;
    logic [FRAC_W-1:0] uz4_reg;

    // Stage 5: column blend and weighted accumulation.
    logic [15:0]      n;
    logic [ACC_W-1:0] acc_next;
    assign n        = lerp_q16(top_reg, bot_reg, uz4_reg);
    assign acc_next = lk_reg[4].acc + ACC_W'({n, 8'b0} >> OCT_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= CELL_STAGES; i++) begin
                lk_reg[i].valid <= 1'b0;
            end
        end else if (advance) begin
            lk_reg[1] <= link_i;
            for (int i = 2; i < CELL_STAGES; i++) begin
                lk_reg[i] <= lk_reg[i-1];
            end
            lk_reg[CELL_STAGES].valid <= lk_reg[CELL_STAGES-1].valid;
            lk_reg[CELL_STAGES].px    <= lk_reg[CELL_STAGES-1].px;
            lk_reg[CELL_STAGES].pz    <= lk_reg[CELL_STAGES-1].pz;
            lk_reg[CELL_STAGES].acc   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            xk_reg    <= xi * HASH_KX;
            zk_reg    <= zi * HASH_KZ;
            seed1_reg <= seed_i + SeedOfs;
            fx_reg    <= fx;
            fz_reg    <= fz;
            fxsq_reg  <= 32'(fx) * 32'(fx);
            fzsq_reg  <= 32'(fz) * 32'(fz);

            g_reg  <= g_next;
            tx_reg <= 34'(fxsq_reg[31:16]) * 34'(tx_poly);
            tz_reg <= 34'(fzsq_reg[31:16]) * 34'(tz_poly);

            for (int c = 0; c < 4; c++) begin
                m_reg[c] <= g_reg[c] * HASH_KM;
            end
            ux_reg <= tx_reg[31:16];
            uz_reg <= tz_reg[31:16];

            top_reg <= lerp_q16(m_reg[0][31:16], m_reg[1][31:16], ux_reg);
            bot_reg <= lerp_q16(m_reg[2][31:16], m_reg[3][31:16], ux_reg);
            uz4_reg <= uz_reg;
        end
    end

    assign link_o = lk_reg[CELL_STAGES];

endmodule

>>> rtl/fractal_value_noise_height_unit.sv
// Fractal value-noise terrain height. Each transaction on the s_ channel
// carries one sample position (pos_x, pos_z, unsigned Q16.8) and yields
// exactly one transaction on the m_ channel carrying the height (unsigned
// Q6.12, saturating just under 35 m). The noise is built by a row of
// OCTAVES octave cells of differing parameters; each cell hashes the four
// lattice corners of its octave, blends them with smoothstep weights and
// adds its weighted value into a running sum that it hands to the next
// cell. A new sample is accepted every clock, one transaction per cycle,
// while the output is not held off. Each cell has five register stages
// (hash multiplies, smoothstep, two blend levels), and the scaling and
// saturation register sits at the output. When the output is held off by
// m_tready, the whole row of cells holds in place and s_tready drops in
// the same cycle. The noise seed is written through the APB port at byte
// address 0 and must only be changed while no transaction is in flight.
module fractal_value_noise_height_unit #(
    parameter int OCTAVES          = 5,
    parameter int BASE_PERIOD_LOG2 = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [23:0] pos_x, [47:24] pos_z
    input  logic [47:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] height, [23:18] zero
    output logic [23:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fvnh_pkg::*;

    // Configuration register.
    logic [31:0] noise_seed_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_NOISE_SEED) ? noise_seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_seed_reg <= 32'd0;
        end else if (cfg_write && paddr[2] == REG_NOISE_SEED) begin
            noise_seed_reg <= pwdata;
        end
    end

    // The chain moves whenever the output register is empty or being drained.
    logic advance;
    logic m_tvalid_reg;
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Link 0 is the incoming sample with an empty sum.
    link_t links [0:OCTAVES];

    assign links[0].valid = s_tvalid;
    assign links[0].px    = s_tdata[POS_W-1:0];
    assign links[0].pz    = s_tdata[2*POS_W-1:POS_W];
    assign links[0].acc   = '0;

    for (genvar o = 0; o < OCTAVES; o++) begin : g_cell
        fvnh_cell #(
            .OCT_IDX    (o),
            .FRAC_SHIFT (8 + BASE_PERIOD_LOG2 - o)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .seed_i  (noise_seed_reg),
            .link_i  (links[o]),
            .link_o  (links[o+1])
        );
    end

    // Scale the octave sum by 18 in Q.24 and bring it to Q6.12 with saturation.
    logic [ACC_W+4:0]    scaled;
    logic [ACC_W-8:0]    height_wide;
    logic [HEIGHT_W-1:0] height_next;
    logic [HEIGHT_W-1:0] height_reg;

    assign scaled      = (ACC_W+5)'(links[OCTAVES].acc) * (ACC_W+5)'(HEIGHT_SCALE);
    assign height_wide = scaled[ACC_W+4:12];
    assign height_next = (height_wide > (ACC_W-7)'(HEIGHT_MAX))
                       ? HEIGHT_MAX : height_wide[HEIGHT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= links[OCTAVES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            height_reg <= height_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, height_reg};

    // A delivered height never exceeds the saturation limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[HEIGHT_W-1:0] <= HEIGHT_MAX))
        else $error("height above saturation limit");

    // While the output is held off, the last cell's valid flag must not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(links[OCTAVES].valid))
        else $error("octave chain moved during a stall");

    // Reset leaves no transaction pending on the output.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
